// File: rtl/hsvsp_pkg.sv
`default_nettype none

package hsvsp_pkg;

  // fixed field widths
  localparam int DIM_W     = 13;
  localparam int PIX_W     = 12;
  localparam int BYTE_W    = 8;
  localparam int OFFSET_W  = 26;
  localparam int CFG_IDX_W = 2;

  // largest usable image size
  localparam logic [DIM_W-1:0] MAX_DIM   = 13'd4096;
  localparam logic [DIM_W-1:0] DIM_RESET = 13'd256;

  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // integer quotient bits of the hue divide (hue sector 0..6)
  localparam int INT_STEPS = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_t;

endpackage

`default_nettype wire

// File: rtl/hsv_spectrum_pixel_generator_top.sv
`default_nettype none

// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+----------------------------------------
// in       | sink      | in_valid / in_stall | pixel_x, pixel_y
// out      | source    | out_valid/out_stall | blue/green/red/alpha_byte, byte_offset
// cfg      | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one pixel a cycle sustained while out_stall is low; pipeline: two front stages, one
// stage per quotient bit of the hue and saturation dividers (FRAC_BITS+3), four colour
// stages. each stage holds its beat until the next one frees, so bubbles close up and
// new beats are taken while a finished result is held by out_stall.
// rst clears the valid bits and loads both sizes with 256; cfg_ready is always high.

module hsv_spectrum_pixel_generator_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [hsvsp_pkg::PIX_W-1:0]      pixel_x,
  input  wire logic [hsvsp_pkg::PIX_W-1:0]      pixel_y,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [hsvsp_pkg::BYTE_W-1:0]     blue_byte,
  output logic      [hsvsp_pkg::BYTE_W-1:0]     green_byte,
  output logic      [hsvsp_pkg::BYTE_W-1:0]     red_byte,
  output logic      [hsvsp_pkg::BYTE_W-1:0]     alpha_byte,
  output logic      [hsvsp_pkg::OFFSET_W-1:0]   byte_offset,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [hsvsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hsvsp_pkg::DIM_W-1:0]      cfg_data
);
  import hsvsp_pkg::*;

  // stage map: front, dividers, colour
  localparam int STEPS   = FRAC_BITS + INT_STEPS;
  localparam int DIV_LO  = 2;
  localparam int COL_LO  = DIV_LO + STEPS;
  localparam int NST     = COL_LO + 4;

  cfg_t                cfg;
  logic [DIM_W-1:0]    size_clamped;

  logic [NST-1:0]      vld;
  logic [NST-1:0]      ready;
  logic [NST-1:0]      vld_up;

  logic [PIX_W+2:0]    hue_num;
  logic [DIM_W-1:0]    hue_den;
  logic [PIX_W-1:0]    sat_num;
  logic [DIM_W-1:0]    sat_den;
  logic [OFFSET_W-1:0] offset;
  logic [STEPS-1:0]    hue_q;
  logic [STEPS-1:0]    sat_q;

  // offset rides alongside, one entry per stage after the front
  logic [OFFSET_W-1:0] off_line [NST-2];

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  // zero acts as one, anything past the limit as the limit
  always_comb begin
    if (cfg_data == '0) begin
      size_clamped = 13'd1;
    end else if (cfg_data > MAX_DIM) begin
      size_clamped = MAX_DIM;
    end else begin
      size_clamped = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= DIM_RESET;
      cfg.height <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  cfg.width  <= size_clamped;
        REG_IMAGE_HEIGHT: cfg.height <= size_clamped;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  // a stage loads when it is empty or its beat moves on
  assign vld_up[0] = in_valid;
  for (genvar i = 1; i < NST; i++) begin : g_up
    assign vld_up[i] = vld[i-1];
  end

  assign ready[NST-1] = !vld[NST-1] || !out_stall;
  for (genvar i = 0; i < NST - 1; i++) begin : g_ready
    assign ready[i] = !vld[i] || ready[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (ready & vld_up) | (~ready & vld);
    end
  end

  assign in_stall  = !ready[0];
  assign out_valid = vld[NST-1];

  // ---------------------------------------------------------------- datapath
  hsvsp_front u_front (
    .clk     (clk),
    .en      (ready[1:0]),
    .cfg     (cfg),
    .pixel_x (pixel_x),
    .pixel_y (pixel_y),
    .hue_num (hue_num),
    .hue_den (hue_den),
    .sat_num (sat_num),
    .sat_den (sat_den),
    .offset  (offset)
  );

  // hue: 6x / (w-1) with FRAC_BITS fraction bits
  hsvsp_div_lane #(
    .STEPS (STEPS),
    .AW    (PIX_W + 3),
    .DW    (DIM_W)
  ) u_hue_div (
    .clk (clk),
    .en  (ready[COL_LO-1:DIV_LO]),
    .num (hue_num),
    .den (hue_den),
    .quo (hue_q)
  );

  // saturation loss: y / (h-1)
  hsvsp_div_lane #(
    .STEPS (STEPS),
    .AW    (PIX_W),
    .DW    (DIM_W)
  ) u_sat_div (
    .clk (clk),
    .en  (ready[COL_LO-1:DIV_LO]),
    .num (sat_num),
    .den (sat_den),
    .quo (sat_q)
  );

  hsvsp_colour #(
    .FRAC_BITS (FRAC_BITS)
  ) u_colour (
    .clk   (clk),
    .en    (ready[NST-1:COL_LO]),
    .hue_q (hue_q),
    .sat_q (sat_q),
    .red   (red_byte),
    .green (green_byte),
    .blue  (blue_byte)
  );

  always_ff @(posedge clk) begin
    if (ready[DIV_LO]) begin
      off_line[0] <= offset;
    end
  end

  for (genvar j = 1; j < NST - 2; j++) begin : g_off
    always_ff @(posedge clk) begin
      if (ready[DIV_LO+j]) begin
        off_line[j] <= off_line[j-1];
      end
    end
  end

  assign byte_offset = off_line[NST-3];
  assign alpha_byte  = ALPHA_OPAQUE;

endmodule

`default_nettype wire

// File: rtl/hsvsp_front.sv
`default_nettype none

module hsvsp_front (
  input  wire logic                            clk,
  input  wire logic [1:0]                      en,
  input  wire hsvsp_pkg::cfg_t                 cfg,
  input  wire logic [hsvsp_pkg::PIX_W-1:0]     pixel_x,
  input  wire logic [hsvsp_pkg::PIX_W-1:0]     pixel_y,
  output logic      [hsvsp_pkg::PIX_W+2:0]     hue_num,
  output logic      [hsvsp_pkg::DIM_W-1:0]     hue_den,
  output logic      [hsvsp_pkg::PIX_W-1:0]     sat_num,
  output logic      [hsvsp_pkg::DIM_W-1:0]     sat_den,
  output logic      [hsvsp_pkg::OFFSET_W-1:0]  offset
);
  import hsvsp_pkg::*;

  logic [DIM_W-1:0]   w_m1;
  logic [DIM_W-1:0]   h_m1;
  logic [PIX_W-1:0]   xs;
  logic [PIX_W-1:0]   ys;
  logic [PIX_W+2:0]   x6;
  logic [PIX_W+DIM_W-1:0] row_prod;
  logic [OFFSET_W-3:0]    pix_index;

  assign w_m1 = cfg.width - 13'd1;
  assign h_m1 = cfg.height - 13'd1;

  // saturate coordinates to the last column / row
  always_ff @(posedge clk) begin
    if (en[0]) begin
      xs <= ({1'b0, pixel_x} >= cfg.width)  ? w_m1[PIX_W-1:0] : pixel_x;
      ys <= ({1'b0, pixel_y} >= cfg.height) ? h_m1[PIX_W-1:0] : pixel_y;
    end
  end

  assign x6        = ({3'b000, xs} << 2) + ({3'b000, xs} << 1);
  assign row_prod  = ys * cfg.width;
  assign pix_index = row_prod[OFFSET_W-3:0] + (OFFSET_W-2)'(xs);

  // size of one divides by one instead (numerator is zero there)
  always_ff @(posedge clk) begin
    if (en[1]) begin
      hue_num <= x6;
      hue_den <= (cfg.width == 13'd1) ? 13'd1 : w_m1;
      sat_num <= ys;
      sat_den <= (cfg.height == 13'd1) ? 13'd1 : h_m1;
      offset  <= {pix_index, 2'b00};
    end
  end

endmodule

`default_nettype wire

// File: rtl/hsvsp_div_lane.sv
`default_nettype none

module hsvsp_div_lane #(
  parameter int STEPS = 19,
  parameter int AW    = 15,
  parameter int DW    = 13
) (
  input  wire logic             clk,
  input  wire logic [STEPS-1:0] en,
  input  wire logic [AW-1:0]    num,
  input  wire logic [DW-1:0]    den,
  output logic      [STEPS-1:0] quo
);
  import hsvsp_pkg::*;

  localparam int RW = DW + INT_STEPS;

  logic [RW-1:0]    rem [STEPS-1];
  logic [DW-1:0]    dsr [STEPS-1];
  logic [STEPS-1:0] qp  [STEPS];

  // one quotient bit per stage, restoring
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [RW-1:0]    r_in;
    logic [DW-1:0]    d_in;
    logic [STEPS-1:0] q_in;
    logic [RW-1:0]    r_sh;
    logic [RW-1:0]    dv;
    logic             qbit;
    logic [RW-1:0]    r_new;

    if (k == 0) begin : g_first
      assign r_in = RW'(num);
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_rest
      assign r_in = rem[k-1];
      assign d_in = dsr[k-1];
      assign q_in = qp[k-1];
    end

    if (k < INT_STEPS) begin : g_int
      assign r_sh = r_in;
      assign dv   = RW'(d_in) << (INT_STEPS - 1 - k);
    end else begin : g_frac
      assign r_sh = r_in << 1;
      assign dv   = RW'(d_in);
    end

    assign qbit  = (r_sh >= dv);
    assign r_new = qbit ? (r_sh - dv) : r_sh;

    always_ff @(posedge clk) begin
      if (en[k]) begin
        qp[k] <= {q_in[STEPS-2:0], qbit};
      end
    end

    if (k < STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem[k] <= r_new;
          dsr[k] <= d_in;
        end
      end
    end
  end

  assign quo = qp[STEPS-1];

endmodule

`default_nettype wire

// File: rtl/hsvsp_colour.sv
`default_nettype none

module hsvsp_colour #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic [3:0]                   en,
  input  wire logic [FRAC_BITS+2:0]         hue_q,
  input  wire logic [FRAC_BITS+2:0]         sat_q,
  output logic      [hsvsp_pkg::BYTE_W-1:0] red,
  output logic      [hsvsp_pkg::BYTE_W-1:0] green,
  output logic      [hsvsp_pkg::BYTE_W-1:0] blue
);
  import hsvsp_pkg::*;

  localparam int F = FRAC_BITS;
  localparam logic [F:0]   ONE  = {1'b1, {F{1'b0}}};
  localparam logic [F+8:0] HALF = (F+9)'(1) << (F - 1);

  logic [2:0]     sec_raw;
  logic           wrap;
  logic [F-1:0]   frac;
  sector_t        sec_w;
  logic [F:0]     t_w;

  sector_t        p1_sec;
  logic [F:0]     p1_c;
  logic [F:0]     p1_t;
  logic [F:0]     p1_m;

  logic [2*F+1:0] prod;
  sector_t        p2_sec;
  logic [F:0]     p2_c;
  logic [F:0]     p2_x;
  logic [F:0]     p2_m;

  logic [F:0]     r_ch;
  logic [F:0]     g_ch;
  logic [F:0]     b_ch;
  logic [F:0]     v_r;
  logic [F:0]     v_g;
  logic [F:0]     v_b;

  logic [F+8:0]   t_r;
  logic [F+8:0]   t_g;
  logic [F+8:0]   t_b;

  // sector and fraction, hue of 360 back to 0
  assign sec_raw = hue_q[F+2:F];
  assign wrap    = (sec_raw >= 3'd6);
  assign frac    = wrap ? '0 : hue_q[F-1:0];
  assign sec_w   = wrap ? SEC_RED_YELLOW : sector_t'(sec_raw);
  assign t_w     = sec_w[0] ? (ONE - {1'b0, frac}) : {1'b0, frac};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1_sec <= sec_w;
      p1_c   <= ONE - sat_q[F:0];
      p1_t   <= t_w;
      p1_m   <= sat_q[F:0];
    end
  end

  assign prod = p1_c * p1_t;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p2_sec <= p1_sec;
      p2_c   <= p1_c;
      p2_x   <= prod[2*F:F];
      p2_m   <= p1_m;
    end
  end

  always_comb begin
    r_ch = p2_c;
    g_ch = '0;
    b_ch = p2_x;
    case (p2_sec)
      SEC_RED_YELLOW:   begin r_ch = p2_c; g_ch = p2_x; b_ch = '0;   end
      SEC_YELLOW_GREEN: begin r_ch = p2_x; g_ch = p2_c; b_ch = '0;   end
      SEC_GREEN_CYAN:   begin r_ch = '0;   g_ch = p2_c; b_ch = p2_x; end
      SEC_CYAN_BLUE:    begin r_ch = '0;   g_ch = p2_x; b_ch = p2_c; end
      SEC_BLUE_MAGENTA: begin r_ch = p2_x; g_ch = '0;   b_ch = p2_c; end
      default:          begin r_ch = p2_c; g_ch = '0;   b_ch = p2_x; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      v_r <= r_ch + p2_m;
      v_g <= g_ch + p2_m;
      v_b <= b_ch + p2_m;
    end
  end

  // v * 255 rounded half-up
  assign t_r = {v_r, 8'b0} - (F+9)'(v_r) + HALF;
  assign t_g = {v_g, 8'b0} - (F+9)'(v_g) + HALF;
  assign t_b = {v_b, 8'b0} - (F+9)'(v_b) + HALF;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      red   <= t_r[F+7:F];
      green <= t_g[F+7:F];
      blue  <= t_b[F+7:F];
    end
  end

endmodule

`default_nettype wire
